// ===== rtl/resp_pkg.sv =====
package resp_pkg;

    localparam int unsigned TDATA_W = 112;

    localparam logic [7:0] KIND_PING     = 8'h83;
    localparam logic [7:0] KIND_UNKNOWN  = 8'h80;
    localparam logic [8:0] PING_BYTES    = 9'd8;
    localparam logic [8:0] UNKNOWN_BYTES = 9'd4;

    typedef enum logic [2:0] {
        RK_PING    = 3'd0,
        RK_HEADER  = 3'd1,
        RK_TEXT    = 3'd2,
        RK_UNKNOWN = 3'd3,
        RK_ERROR   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [29:0] event_time;
        logic [3:0]  player_id;
        logic [1:0]  message_target;
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic [7:0]  text_byte;
        logic        last_of_event;
    } t_result;

endpackage

// ===== rtl/replay_event_stream_parser_unit.sv =====
// replay event stream parser
// slave stream: one raw event byte per transfer on i_s_axis_tdata[7:0]
// master stream: one decoded result per transfer; tuser carries the result
// kind (ping, message header, message text byte, unknown event, error),
// tlast marks the final result of an event, tdata carries the event time,
// player, message target, the two words and the text byte
// most bytes (timestamp, player, kind, partial body) give no result; a
// completed ping or unknown body, a message length byte, each message text
// byte and a bad kind byte each give exactly one result
// throughput: one byte per cycle while the master side does not stall
// latency: a result appears on the master side the cycle after its byte
// is taken, from the output register
// a stall on the master side holds the result register and drops the
// slave side ready, so no byte is taken while the result waits; any byte
// is taken again in the cycle the held result is taken
// reset (synchronous, active low) empties the output register and puts
// the parser back at the first timestamp byte of an event
module replay_event_stream_parser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // data_byte
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // event_time, player_id, message_target, first_word, second_word,
    // text_byte, zero pad
    output logic [resp_pkg::TDATA_W-1:0]  o_m_axis_tdata,
    output logic [2:0]                    o_m_axis_tuser,  // result_kind
    output logic                          o_m_axis_tlast   // last_of_event
);
    import resp_pkg::*;

    logic    in_fire;
    logic    res_valid;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    resp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_fire),
        .i_byte      (i_s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last_of_event;
    assign o_m_axis_tdata  = {4'd0, r_out.text_byte, r_out.second_word, r_out.first_word,
                              r_out.message_target, r_out.player_id, r_out.event_time};

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !res_valid)
        else $error("result register overwritten while stalled");

    a_close_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == RK_ERROR || o_m_axis_tuser == RK_PING
            || o_m_axis_tuser == RK_UNKNOWN)) |-> o_m_axis_tlast)
        else $error("ping, unknown or error result not last of event");

    a_text_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == RK_TEXT) |-> (o_m_axis_tdata[67:36] != 32'd0))
        else $error("text byte with zero message length");
`endif

endmodule

// ===== rtl/resp_core.sv =====
module resp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output resp_pkg::t_result o_res
);
    import resp_pkg::*;

    typedef enum logic [2:0] {
        PH_TS_FIRST,
        PH_TS_EXTRA,
        PH_PLAYER,
        PH_KIND,
        PH_PING,
        PH_UNKNOWN,
        PH_MSG_LEN,
        PH_TEXT
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [29:0] r_time,    n_time;
    logic [8:0]  r_left,    n_left;
    logic [3:0]  r_player,  n_player;
    logic [1:0]  r_target,  n_target;
    logic [8:0]  r_len,     n_len;
    logic [31:0] r_word_a,  n_word_a;
    logic [31:0] r_word_b,  n_word_b;
    logic [2:0]  ping_pos;
    logic [1:0]  unk_pos;

    assign ping_pos = 3'(3'd0 - r_left[2:0]);
    assign unk_pos  = 2'(2'd0 - r_left[1:0]);

    always_comb begin
        n_phase  = r_phase;
        n_time   = r_time;
        n_left   = r_left;
        n_player = r_player;
        n_target = r_target;
        n_len    = r_len;
        n_word_a = r_word_a;
        n_word_b = r_word_b;
        o_res_valid = 1'b0;
        o_res = '0;
        o_res.event_time = r_time;
        o_res.player_id  = r_player;
        if (i_valid) begin
            unique case (r_phase)
                PH_TS_FIRST: begin
                    n_time  = 30'(i_byte[7:2]);
                    n_left  = 9'(i_byte[1:0]);
                    n_phase = (i_byte[1:0] != 2'd0) ? PH_TS_EXTRA : PH_PLAYER;
                end
                PH_TS_EXTRA: begin
                    n_time = {r_time[21:0], i_byte};
                    n_left = r_left - 9'd1;
                    if (n_left == 9'd0) begin
                        n_phase = PH_PLAYER;
                    end
                end
                PH_PLAYER: begin
                    n_player = i_byte[3:0];
                    n_phase  = PH_KIND;
                end
                PH_KIND: begin
                    if (i_byte == KIND_PING) begin
                        n_word_a = '0;
                        n_word_b = '0;
                        n_left   = PING_BYTES;
                        n_phase  = PH_PING;
                    end else if (i_byte == KIND_UNKNOWN) begin
                        n_word_a = '0;
                        n_word_b = '0;
                        n_left   = UNKNOWN_BYTES;
                        n_phase  = PH_UNKNOWN;
                    end else if (!i_byte[7]) begin
                        n_target = i_byte[1:0];
                        n_len    = {1'b0, i_byte[4:3], 6'd0};
                        n_phase  = PH_MSG_LEN;
                    end else begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = RK_ERROR;
                        o_res.last_of_event = 1'b1;
                        n_phase             = PH_TS_FIRST;
                    end
                end
                PH_PING: begin
                    if (!ping_pos[2]) begin
                        n_word_a[ping_pos[1:0]*8 +: 8] = i_byte;
                    end else begin
                        n_word_b[ping_pos[1:0]*8 +: 8] = i_byte;
                    end
                    n_left = r_left - 9'd1;
                    if (n_left == 9'd0) begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = RK_PING;
                        o_res.first_word    = n_word_a;
                        o_res.second_word   = n_word_b;
                        o_res.last_of_event = 1'b1;
                        n_phase             = PH_TS_FIRST;
                    end
                end
                PH_UNKNOWN: begin
                    n_word_a[unk_pos*8 +: 8] = i_byte;
                    n_left = r_left - 9'd1;
                    if (n_left == 9'd0) begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = RK_UNKNOWN;
                        o_res.first_word    = n_word_a;
                        o_res.last_of_event = 1'b1;
                        n_phase             = PH_TS_FIRST;
                    end
                end
                PH_MSG_LEN: begin
                    n_len  = r_len + 9'(i_byte);
                    n_left = n_len;
                    o_res_valid          = 1'b1;
                    o_res.kind           = RK_HEADER;
                    o_res.message_target = r_target;
                    o_res.first_word     = 32'(n_len);
                    o_res.last_of_event  = (n_len == 9'd0);
                    n_phase = (n_len == 9'd0) ? PH_TS_FIRST : PH_TEXT;
                end
                PH_TEXT: begin
                    n_left = r_left - 9'd1;
                    o_res_valid          = 1'b1;
                    o_res.kind           = RK_TEXT;
                    o_res.message_target = r_target;
                    o_res.first_word     = 32'(r_len);
                    o_res.text_byte      = i_byte;
                    o_res.last_of_event  = (n_left == 9'd0);
                    if (n_left == 9'd0) begin
                        n_phase = PH_TS_FIRST;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TS_FIRST;
            r_time   <= '0;
            r_left   <= '0;
            r_player <= '0;
            r_target <= '0;
            r_len    <= '0;
            r_word_a <= '0;
            r_word_b <= '0;
        end else begin
            r_phase  <= n_phase;
            r_time   <= n_time;
            r_left   <= n_left;
            r_player <= n_player;
            r_target <= n_target;
            r_len    <= n_len;
            r_word_a <= n_word_a;
            r_word_b <= n_word_b;
        end
    end

endmodule
